// ----- rtl/ufc_pkg.sv -----
// Shared types and constants for the timestamped union-find connectivity block.
// Used by ufc_engine and by the top level; depends on nothing else.
package ufc_pkg;

    // Fixed widths of the item fields.
    localparam int VERTEX_WIDTH = 10;
    localparam int QTIME_WIDTH  = 32;
    localparam int SIZE_WIDTH   = 11;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_WIDTH = 56;
    localparam int M_DATA_WIDTH = 8;

    // Command codes carried in tuser.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One accepted item as handed to the engine.
    typedef struct packed {
        logic                    is_query;
        logic                    walk;        // tracking on and both vertices in range
        logic [VERTEX_WIDTH-1:0] vertex_a;
        logic [VERTEX_WIDTH-1:0] vertex_b;
        logic [QTIME_WIDTH-1:0]  query_time;
    } t_cmd;

    // Result handed from the engine to the output register.
    typedef struct packed {
        logic valid;
        logic connected;
    } t_res;

endpackage

// ----- rtl/ufc_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.
module ufc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ----- rtl/ufc_engine.sv -----
// Sequencer for the union-find forest: clearing pass, root walks, linking.
// Depends on ufc_pkg and keeps the forest in one ufc_ram instance.
module ufc_engine import ufc_pkg::*; #(
    parameter int NODES      = 1024,
    parameter int TIME_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_ready,
    output t_res o_res,
    input  logic i_res_ready
);

    localparam int AW = $clog2(NODES);
    localparam int TW = TIME_WIDTH;
    localparam int SW = SIZE_WIDTH;
    localparam int CW = (TW > QTIME_WIDTH) ? TW : QTIME_WIDTH;
    // Entry layout: {has_parent, parent, link_time, set_size}.
    localparam int WW       = 1 + AW + TW + SW;
    localparam int TIME_LSB = SW;
    localparam int PAR_LSB  = SW + TW;
    localparam int HAS_BIT  = SW + TW + AW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_LINK,
        S_GROW,
        S_RESULT
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr_idx;
    logic [TW-1:0]   r_clock;
    logic            r_query;
    logic [AW-1:0]   r_b;
    logic [QTIME_WIDTH-1:0] r_qt;
    logic [AW-1:0]   r_cur;
    logic            r_side;
    logic [AW-1:0]   r_root_a;
    logic [AW-1:0]   r_root_b;
    logic [WW-1:0]   r_word_a;
    logic [WW-1:0]   r_word_b;
    logic            r_conn;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [WW-1:0]   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [WW-1:0]   rd_data;

    logic            rd_has;
    logic [AW-1:0]   rd_parent;
    logic [TW-1:0]   rd_time;
    logic            follow;
    logic [SW-1:0]   size_a;
    logic [SW-1:0]   size_b;
    logic            swap;
    logic [AW-1:0]   big_root;
    logic [AW-1:0]   small_root;
    logic [WW-1:0]   big_word;
    logic [SW-1:0]   small_size;
    logic [SW-1:0]   size_sum;

    ufc_ram #(
        .WIDTH (WW),
        .DEPTH (NODES)
    ) u_forest (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Fields of the entry just read; queries only follow links made by their time.
    assign rd_has    = rd_data[HAS_BIT];
    assign rd_parent = rd_data[PAR_LSB +: AW];
    assign rd_time   = rd_data[TIME_LSB +: TW];
    assign follow    = rd_has && (!r_query || (CW'(rd_time) <= CW'(r_qt)));

    // Union by size: the smaller set goes under the larger, b under a on a tie.
    assign size_a     = r_word_a[SW-1:0];
    assign size_b     = r_word_b[SW-1:0];
    assign swap       = size_a < size_b;
    assign big_root   = swap ? r_root_b : r_root_a;
    assign small_root = swap ? r_root_a : r_root_b;
    assign big_word   = swap ? r_word_b : r_word_a;
    assign small_size = swap ? size_a : size_b;
    assign size_sum   = size_a + size_b;

    // Memory port control.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_cur;
        wr_en   = 1'b0;
        wr_addr = r_clr_idx;
        wr_data = {1'b0, {AW{1'b0}}, {TW{1'b0}}, SW'(1)};
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                rd_en   = i_cmd_valid && i_cmd.walk;
                rd_addr = AW'(i_cmd.vertex_a);
            end
            S_WALK: begin
                rd_en   = follow || !r_side;
                rd_addr = follow ? rd_parent : r_b;
            end
            S_LINK: begin
                wr_en   = 1'b1;
                wr_addr = small_root;
                wr_data = {1'b1, big_root, r_clock, small_size};
            end
            S_GROW: begin
                wr_en   = 1'b1;
                wr_addr = big_root;
                wr_data = {big_word[WW-1:SW], size_sum};
            end
            S_RESULT: begin
                rd_en = 1'b0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer state and registered results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_clock   <= '0;
            r_side    <= 1'b0;
            r_conn    <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == AW'(NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_query <= i_cmd.is_query;
                        r_b     <= AW'(i_cmd.vertex_b);
                        r_qt    <= i_cmd.query_time;
                        r_cur   <= AW'(i_cmd.vertex_a);
                        r_side  <= 1'b0;
                        if (!i_cmd.is_query && (r_clock != {TW{1'b1}})) begin
                            r_clock <= r_clock + TW'(1);
                        end
                        if (i_cmd.walk) begin
                            r_state <= S_WALK;
                        end else if (i_cmd.is_query) begin
                            r_conn  <= 1'b0;
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_WALK: begin
                    if (follow) begin
                        r_cur <= rd_parent;
                    end else if (!r_side) begin
                        // Root of vertex a found; start on vertex b.
                        r_root_a <= r_cur;
                        r_word_a <= rd_data;
                        r_side   <= 1'b1;
                        r_cur    <= r_b;
                    end else begin
                        r_root_b <= r_cur;
                        r_word_b <= rd_data;
                        if (r_query) begin
                            r_conn  <= (r_root_a == r_cur);
                            r_state <= S_RESULT;
                        end else if (r_root_a != r_cur) begin
                            r_state <= S_LINK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_LINK: begin
                    r_state <= S_GROW;
                end
                S_GROW: begin
                    r_state <= S_IDLE;
                end
                S_RESULT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_ready     = (r_state == S_IDLE);
    assign o_res.valid     = (r_state == S_RESULT);
    assign o_res.connected = r_conn;

endmodule

// ----- rtl/timestamped_union_find_connectivity.sv -----
// Top level of the timestamped union-find connectivity block: stream ports,
// enable register, range check and output register. Depends on ufc_pkg and ufc_engine.
//
// The block keeps a union-find forest over NODES vertices in one RAM, each link
// stamped with the edge clock at which it was made. After reset it runs a
// clearing pass over all NODES entries, during which s_axis_tready stays low
// (enable writes are taken as ever). Items are handled one at a time: an item
// is accepted, then the forest RAM is read once per node visited on each of the
// two root walks (depth plus one reads per vertex, depth at most about log2 NODES
// thanks to union by size), then an add that joins two sets writes the link and
// then the new set size, while a query hands its result to the output register
// once that can take it. The registered read of the forest RAM sets the walk
// pace. Adds with tracking off or an out-of-range vertex skip the walks, and such
// queries report not connected.
module timestamped_union_find_connectivity import ufc_pkg::*; #(
    parameter int NODES      = 1024,
    parameter int TIME_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Enable register write.
    input  logic                    i_cfg_wen,
    input  logic                    i_cfg_wdata,
    // Input items.
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: vertex_a [9:0], vertex_b [19:10], query_time [51:20], zeros above.
    input  logic [S_DATA_WIDTH-1:0] s_axis_tdata,
    // tuser: command [0] (0 adds an edge, 1 queries).
    input  logic                    s_axis_tuser,
    // Result items.
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata: connected [0], zeros above.
    output logic [M_DATA_WIDTH-1:0] m_axis_tdata
);

    logic r_enable;
    logic r_m_valid;
    logic r_m_connected;

    logic [VERTEX_WIDTH-1:0] w_vertex_a;
    logic [VERTEX_WIDTH-1:0] w_vertex_b;
    logic                    in_range;
    t_cmd                    cmd;
    t_res                    res;
    logic                    res_ready;

    // Tracking enable register, set after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_wen) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // Unpack the item; only in-range vertices with tracking on are walked.
    assign w_vertex_a = s_axis_tdata[VERTEX_WIDTH-1:0];
    assign w_vertex_b = s_axis_tdata[2*VERTEX_WIDTH-1:VERTEX_WIDTH];
    assign in_range   = (32'(w_vertex_a) < 32'(NODES)) && (32'(w_vertex_b) < 32'(NODES));

    assign cmd.is_query   = (s_axis_tuser == CMD_QUERY);
    assign cmd.walk       = r_enable && in_range;
    assign cmd.vertex_a   = w_vertex_a;
    assign cmd.vertex_b   = w_vertex_b;
    assign cmd.query_time = s_axis_tdata[2*VERTEX_WIDTH +: QTIME_WIDTH];

    ufc_engine #(
        .NODES      (NODES),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_axis_tvalid),
        .i_cmd       (cmd),
        .o_cmd_ready (s_axis_tready),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Output register; it takes a new result whenever the old one is gone.
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_m_connected <= res.connected;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(M_DATA_WIDTH-1){1'b0}}, r_m_connected};

endmodule
